// ----- rtl/core/first_fit_block_allocator_core_macros.svh -----
// assertion macros shared by the allocator checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// condition must hold in the same cycle
`define FFBA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define FFBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ffba_pkg.sv -----
// shared types and constants of the first-fit block allocator
package ffba_pkg;

    localparam int OPCODE_W   = 3;
    localparam int REQ_W      = 20;
    localparam int ALIGN_W    = 13;
    localparam int BADDR_W    = 20;
    localparam int RADDR_W    = 20;
    localparam int STATUS_W   = 2;
    localparam int LFREE_W    = 21;
    localparam int HEAP_W     = 21;
    localparam int REM_W      = 13;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // output tdata layout
    localparam int OUT_SUCC_BIT = 20;
    localparam int OUT_STAT_LO  = 21;
    localparam int OUT_LFREE_LO = 23;

    localparam logic [HEAP_W-1:0] HEAP_RESET = 21'd1048576;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_COLLECT = 3'd2,
        OP_QUERY   = 3'd3,
        OP_LARGEST = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NOTOUT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

// ----- rtl/core/ffba_mod_unit.sv -----
// restoring remainder unit, one dividend bit per cycle
module ffba_mod_unit
    import ffba_pkg::*;
#(
    parameter int DW = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DW-1:0]    dividend,
    input  logic [REM_W-1:0] divisor,
    output logic             done,
    output logic [REM_W-1:0] rem
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [REM_W:0]   rem_reg, rem_next;
    logic [REM_W-1:0] div_reg, div_next;
    logic [REM_W:0]   trial;

    always_comb begin
        trial     = {rem_reg[REM_W-1:0], dvd_reg[DW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial - {1'b0, div_reg};
            end else begin
                rem_next = trial;
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[REM_W-1:0];

endmodule

// ----- rtl/core/first_fit_block_allocator_core.sv -----
// First-fit heap allocator with coalescing. One request is taken at a time and
// s_tready stays low until its result is loaded into the output register. The
// free-segment table is scanned one entry at a time; an allocate also runs the
// remainder unit for each candidate segment, so its cost grows with the segments
// visited. Free and is-allocated scan the used table one slot at a time, and a
// sorted insert or removal moves one segment at a time. After reset or a
// heap_bytes write the block forms the heap in its init state before it takes a
// request.
module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int ADDR_BITS    = 20,
    parameter int FREE_ENTRIES = 64,
    parameter int USED_ENTRIES = 64,
    parameter int DESC_BYTES   = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [HEAP_W-1:0]     cfg_wdata,   // heap_bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // request_bytes, align_bytes, block_address
    input  logic [OPCODE_W-1:0]   s_tuser,     // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata      // result_address, success, status, largest_free
);

    localparam int SZW = ADDR_BITS + 1;
    localparam int XW  = (ADDR_BITS > 20 ? ADDR_BITS : 20) + 2;
    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int UIW = $clog2(USED_ENTRIES);
    localparam int UCW = $clog2(USED_ENTRIES + 1);
    localparam logic [XW-1:0] DESC_X = XW'(DESC_BYTES);
    localparam logic [XW-1:0] HMIN   = XW'(DESC_BYTES > 64 ? DESC_BYTES : 64);
    localparam logic [XW-1:0] HMAX   = XW'(1) << ADDR_BITS;

    typedef enum logic [22:0] {
        S_INIT   = 23'd1 << 0,
        S_IDLE   = 23'd1 << 1,
        S_SLOT   = 23'd1 << 2,
        S_ARD    = 23'd1 << 3,
        S_AMOD   = 23'd1 << 4,
        S_AWAIT  = 23'd1 << 5,
        S_ACHK   = 23'd1 << 6,
        S_URD    = 23'd1 << 7,
        S_UCHK   = 23'd1 << 8,
        S_PRD    = 23'd1 << 9,
        S_PCHK   = 23'd1 << 10,
        S_FMRG   = 23'd1 << 11,
        S_SHD_RD = 23'd1 << 12,
        S_SHD_WR = 23'd1 << 13,
        S_SHU_RD = 23'd1 << 14,
        S_SHU_WR = 23'd1 << 15,
        S_CRD0   = 23'd1 << 16,
        S_CLD    = 23'd1 << 17,
        S_CRD    = 23'd1 << 18,
        S_CCHK   = 23'd1 << 19,
        S_LRD    = 23'd1 << 20,
        S_LCHK   = 23'd1 << 21,
        S_RESP   = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    logic [HEAP_W-1:0]     heap_reg;
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [ALIGN_W-1:0]    align_reg, align_next;
    logic [BADDR_W-1:0]    addr_reg, addr_next;
    logic [UCW-1:0]        uidx_reg, uidx_next;
    logic [UIW-1:0]        slot_reg, slot_next;
    logic [FCW-1:0]        fidx_reg, fidx_next;
    logic [FCW-1:0]        pos_reg, pos_next;
    logic [FCW-1:0]        count_reg, count_next;
    logic [SZW-1:0]        cur_start_reg, cur_start_next;
    logic [SZW-1:0]        cur_size_reg, cur_size_next;
    logic                  cur_ok_reg, cur_ok_next;
    logic [SZW-1:0]        prev_start_reg, prev_start_next;
    logic [XW-1:0]         prev_end_reg, prev_end_next;
    logic [XW-1:0]         base_reg, base_next;
    logic [XW-1:0]         bend_reg, bend_next;
    logic [SZW-1:0]        best_reg, best_next;
    logic                  ret_coll_reg, ret_coll_next;
    logic [USED_ENTRIES-1:0] valid_reg, valid_next;
    logic [RADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic                  res_succ_reg, res_succ_next;
    logic [STATUS_W-1:0]   res_stat_reg, res_stat_next;
    logic [LFREE_W-1:0]    res_lfree_reg, res_lfree_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // free-segment table
    logic [SZW-1:0] fs_start_mem [FREE_ENTRIES];
    logic [SZW-1:0] fs_size_mem  [FREE_ENTRIES];
    logic [SZW-1:0] fs_rstart_reg, fs_rsize_reg;
    logic           fs_we;
    logic [FIW-1:0] fs_waddr, fs_raddr;
    logic [SZW-1:0] fs_wstart, fs_wsize;

    // outstanding-block table
    logic [ADDR_BITS-1:0] us_user_mem [USED_ENTRIES];
    logic [ADDR_BITS-1:0] us_base_mem [USED_ENTRIES];
    logic [SZW-1:0]       us_span_mem [USED_ENTRIES];
    logic [ADDR_BITS-1:0] us_ruser_reg, us_rbase_reg;
    logic [SZW-1:0]       us_rspan_reg;
    logic                 us_we;
    logic [ADDR_BITS-1:0] us_wuser, us_wbase;
    logic [SZW-1:0]       us_wspan;

    logic             mod_start, mod_done;
    logic [XW-1:0]    mod_dividend;
    logic [REM_W-1:0] mod_divisor, mod_rem;

    logic [XW-1:0] heap_x, heap_c;
    logic [XW-1:0] raw, pad, user, total, cend, nsum;
    logic          fit, mp, mn, s_acc;
    logic [ALIGN_W-1:0] align_eff;

    ffba_mod_unit #(.DW(XW)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb begin
        heap_x = XW'(heap_reg);
        if (heap_x < HMIN) begin
            heap_c = HMIN;
        end else if (heap_x > HMAX) begin
            heap_c = HMAX;
        end else begin
            heap_c = heap_x;
        end
        align_eff    = (align_reg == '0) ? ALIGN_W'(1) : align_reg;
        raw          = XW'(cur_start_reg) + DESC_X;
        pad          = (mod_rem == '0) ? '0 : XW'(align_eff) - XW'(mod_rem);
        user         = raw + pad;
        total        = XW'(req_reg) + DESC_X + pad;
        fit          = (XW'(cur_size_reg) >= total) && (user < HMAX);
        cend         = XW'(cur_start_reg) + XW'(cur_size_reg);
        nsum         = XW'(fs_rstart_reg) + XW'(fs_rsize_reg);
        mp           = (fidx_reg != '0) && (prev_end_reg == base_reg);
        mn           = cur_ok_reg && (XW'(cur_start_reg) == bend_reg);
        mod_dividend = XW'(fs_rstart_reg) + DESC_X;
        mod_divisor  = align_eff;
        s_acc        = s_tvalid && s_tready;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        align_next      = align_reg;
        addr_next       = addr_reg;
        uidx_next       = uidx_reg;
        slot_next       = slot_reg;
        fidx_next       = fidx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        cur_start_next  = cur_start_reg;
        cur_size_next   = cur_size_reg;
        cur_ok_next     = cur_ok_reg;
        prev_start_next = prev_start_reg;
        prev_end_next   = prev_end_reg;
        base_next       = base_reg;
        bend_next       = bend_reg;
        best_next       = best_reg;
        ret_coll_next   = ret_coll_reg;
        valid_next      = valid_reg;
        res_addr_next   = res_addr_reg;
        res_succ_next   = res_succ_reg;
        res_stat_next   = res_stat_reg;
        res_lfree_next  = res_lfree_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        fs_we           = 1'b0;
        fs_waddr        = fidx_reg[FIW-1:0];
        fs_wstart       = cur_start_reg;
        fs_wsize        = cur_size_reg;
        fs_raddr        = fidx_reg[FIW-1:0];
        us_we           = 1'b0;
        us_wuser        = ADDR_BITS'(user);
        us_wbase        = ADDR_BITS'(raw);
        us_wspan        = SZW'(XW'(req_reg) + pad);
        mod_start       = 1'b0;

        unique case (state_reg)
            S_INIT: begin
                fs_we      = 1'b1;
                fs_waddr   = '0;
                fs_wstart  = SZW'(DESC_BYTES);
                fs_wsize   = SZW'(heap_c - DESC_X);
                count_next = FCW'(1);
                valid_next = '0;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) begin
                    op_next        = s_tuser;
                    req_next       = s_tdata[REQ_W-1:0];
                    align_next     = s_tdata[REQ_W +: ALIGN_W];
                    addr_next      = s_tdata[REQ_W+ALIGN_W +: BADDR_W];
                    uidx_next      = '0;
                    fidx_next      = '0;
                    best_next      = '0;
                    res_addr_next  = '0;
                    res_succ_next  = 1'b0;
                    res_stat_next  = ST_OK;
                    res_lfree_next = '0;
                    case (s_tuser)
                        OP_ALLOC:   state_next = S_SLOT;
                        OP_FREE:    state_next = S_URD;
                        OP_QUERY:   state_next = S_URD;
                        OP_COLLECT: begin
                            res_succ_next = 1'b1;
                            state_next    = S_CRD0;
                        end
                        OP_LARGEST: begin
                            res_succ_next = 1'b1;
                            state_next    = S_LRD;
                        end
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_SLOT: begin
                if (!valid_reg[uidx_reg[UIW-1:0]]) begin
                    slot_next  = uidx_reg[UIW-1:0];
                    state_next = S_ARD;
                end else if (uidx_reg == UCW'(USED_ENTRIES - 1)) begin
                    res_stat_next = ST_FULL;
                    state_next    = S_RESP;
                end else begin
                    uidx_next = uidx_reg + 1'b1;
                end
            end
            S_ARD: begin
                if (fidx_reg >= count_reg) begin
                    res_stat_next = ST_NOFIT;
                    state_next    = S_RESP;
                end else begin
                    state_next = S_AMOD;
                end
            end
            S_AMOD: begin
                cur_start_next = fs_rstart_reg;
                cur_size_next  = fs_rsize_reg;
                mod_start      = 1'b1;
                state_next     = S_AWAIT;
            end
            S_AWAIT: begin
                if (mod_done) state_next = S_ACHK;
            end
            S_ACHK: begin
                if (fit) begin
                    fs_we     = 1'b1;
                    fs_wstart = SZW'(XW'(cur_start_reg) + total);
                    fs_wsize  = SZW'(XW'(cur_size_reg) - total);
                    us_we     = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    res_addr_next = RADDR_W'(user);
                    res_succ_next = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    fidx_next  = fidx_reg + 1'b1;
                    state_next = S_ARD;
                end
            end
            S_URD: begin
                if (uidx_reg == UCW'(USED_ENTRIES)) begin
                    if (op_reg == OP_FREE) res_stat_next = ST_NOTOUT;
                    state_next = S_RESP;
                end else begin
                    state_next = S_UCHK;
                end
            end
            S_UCHK: begin
                if (valid_reg[uidx_reg[UIW-1:0]] &&
                    (XW'(us_ruser_reg) == XW'(addr_reg))) begin
                    if (op_reg == OP_QUERY) begin
                        res_succ_next = 1'b1;
                        state_next    = S_RESP;
                    end else begin
                        slot_next  = uidx_reg[UIW-1:0];
                        base_next  = XW'(us_rbase_reg);
                        bend_next  = XW'(us_rbase_reg) + XW'(us_rspan_reg);
                        fidx_next  = '0;
                        state_next = S_PRD;
                    end
                end else begin
                    uidx_next  = uidx_reg + 1'b1;
                    state_next = S_URD;
                end
            end
            S_PRD: begin
                if (fidx_reg >= count_reg) begin
                    cur_ok_next = 1'b0;
                    state_next  = S_FMRG;
                end else begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK: begin
                if (XW'(fs_rstart_reg) >= base_reg) begin
                    cur_start_next = fs_rstart_reg;
                    cur_size_next  = fs_rsize_reg;
                    cur_ok_next    = 1'b1;
                    state_next     = S_FMRG;
                end else begin
                    prev_start_next = fs_rstart_reg;
                    prev_end_next   = nsum;
                    fidx_next       = fidx_reg + 1'b1;
                    state_next      = S_PRD;
                end
            end
            S_FMRG: begin
                // merge into previous, next, both, or insert a new segment if the table has room
                if (mp && mn) begin
                    fs_we         = 1'b1;
                    fs_waddr      = FIW'(fidx_reg - 1'b1);
                    fs_wstart     = prev_start_reg;
                    fs_wsize      = SZW'(cend - XW'(prev_start_reg));
                    fidx_next     = fidx_reg + 1'b1;
                    ret_coll_next = 1'b0;
                    state_next    = S_SHD_RD;
                end else if (mp) begin
                    fs_we      = 1'b1;
                    fs_waddr   = FIW'(fidx_reg - 1'b1);
                    fs_wstart  = prev_start_reg;
                    fs_wsize   = SZW'(bend_reg - XW'(prev_start_reg));
                    valid_next[slot_reg] = 1'b0;
                    res_succ_next = 1'b1;
                    state_next    = S_RESP;
                end else if (mn) begin
                    fs_we      = 1'b1;
                    fs_wstart  = SZW'(base_reg);
                    fs_wsize   = SZW'(cend - base_reg);
                    valid_next[slot_reg] = 1'b0;
                    res_succ_next = 1'b1;
                    state_next    = S_RESP;
                end else if (count_reg >= FCW'(FREE_ENTRIES)) begin
                    res_stat_next = ST_FULL;
                    state_next    = S_RESP;
                end else begin
                    pos_next   = fidx_reg;
                    fidx_next  = count_reg;
                    state_next = S_SHU_RD;
                end
            end
            S_SHD_RD: begin
                if (fidx_reg >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    if (ret_coll_reg) begin
                        state_next = S_CRD;
                    end else begin
                        valid_next[slot_reg] = 1'b0;
                        res_succ_next = 1'b1;
                        state_next    = S_RESP;
                    end
                end else begin
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR: begin
                fs_we      = 1'b1;
                fs_waddr   = FIW'(fidx_reg - 1'b1);
                fs_wstart  = fs_rstart_reg;
                fs_wsize   = fs_rsize_reg;
                fidx_next  = fidx_reg + 1'b1;
                state_next = S_SHD_RD;
            end
            S_SHU_RD: begin
                if (fidx_reg == pos_reg) begin
                    fs_we      = 1'b1;
                    fs_wstart  = SZW'(base_reg);
                    fs_wsize   = SZW'(bend_reg - base_reg);
                    count_next = count_reg + 1'b1;
                    valid_next[slot_reg] = 1'b0;
                    res_succ_next = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    fs_raddr   = FIW'(fidx_reg - 1'b1);
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR: begin
                fs_we      = 1'b1;
                fs_wstart  = fs_rstart_reg;
                fs_wsize   = fs_rsize_reg;
                fidx_next  = fidx_reg - 1'b1;
                state_next = S_SHU_RD;
            end
            S_CRD0: begin
                pos_next   = '0;
                fs_raddr   = '0;
                state_next = S_CLD;
            end
            S_CLD: begin
                cur_start_next = fs_rstart_reg;
                cur_size_next  = fs_rsize_reg;
                state_next     = S_CRD;
            end
            S_CRD: begin
                if (XW'(pos_reg) + XW'(1) >= XW'(count_reg)) begin
                    state_next = S_RESP;
                end else begin
                    fs_raddr   = FIW'(pos_reg + 1'b1);
                    state_next = S_CCHK;
                end
            end
            S_CCHK: begin
                if ((cend == XW'(fs_rstart_reg)) ||
                    (cend + DESC_X == XW'(fs_rstart_reg))) begin
                    cur_size_next = SZW'(nsum - XW'(cur_start_reg));
                    fs_we         = 1'b1;
                    fs_waddr      = pos_reg[FIW-1:0];
                    fs_wsize      = SZW'(nsum - XW'(cur_start_reg));
                    fidx_next     = pos_reg + FCW'(2);
                    ret_coll_next = 1'b1;
                    state_next    = S_SHD_RD;
                end else begin
                    pos_next       = pos_reg + 1'b1;
                    cur_start_next = fs_rstart_reg;
                    cur_size_next  = fs_rsize_reg;
                    state_next     = S_CRD;
                end
            end
            S_LRD: begin
                if (fidx_reg >= count_reg) begin
                    res_lfree_next = LFREE_W'(best_reg);
                    state_next     = S_RESP;
                end else begin
                    state_next = S_LCHK;
                end
            end
            S_LCHK: begin
                if (fs_rsize_reg > best_reg) best_next = fs_rsize_reg;
                fidx_next  = fidx_reg + 1'b1;
                state_next = S_LRD;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_DATA_W - OUT_LFREE_LO - LFREE_W){1'b0}},
                                     res_lfree_reg, res_stat_reg, res_succ_reg,
                                     res_addr_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase

        if (cfg_we) state_next = S_INIT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            heap_reg     <= HEAP_RESET;
            count_reg    <= FCW'(1);
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) heap_reg <= cfg_wdata;
        end
        op_reg         <= op_next;
        req_reg        <= req_next;
        align_reg      <= align_next;
        addr_reg       <= addr_next;
        uidx_reg       <= uidx_next;
        slot_reg       <= slot_next;
        fidx_reg       <= fidx_next;
        pos_reg        <= pos_next;
        cur_start_reg  <= cur_start_next;
        cur_size_reg   <= cur_size_next;
        cur_ok_reg     <= cur_ok_next;
        prev_start_reg <= prev_start_next;
        prev_end_reg   <= prev_end_next;
        base_reg       <= base_next;
        bend_reg       <= bend_next;
        best_reg       <= best_next;
        ret_coll_reg   <= ret_coll_next;
        res_addr_reg   <= res_addr_next;
        res_succ_reg   <= res_succ_next;
        res_stat_reg   <= res_stat_next;
        res_lfree_reg  <= res_lfree_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_start_mem[fs_waddr] <= fs_wstart;
            fs_size_mem[fs_waddr]  <= fs_wsize;
        end
        fs_rstart_reg <= fs_start_mem[fs_raddr];
        fs_rsize_reg  <= fs_size_mem[fs_raddr];
    end

    always_ff @(posedge aclk) begin
        if (us_we) begin
            us_user_mem[slot_reg] <= us_wuser;
            us_base_mem[slot_reg] <= us_wbase;
            us_span_mem[slot_reg] <= us_wspan;
        end
        us_ruser_reg <= us_user_mem[uidx_reg[UIW-1:0]];
        us_rbase_reg <= us_base_mem[uidx_reg[UIW-1:0]];
        us_rspan_reg <= us_span_mem[uidx_reg[UIW-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/ffba_checker.sv -----
// port-level checks for the allocator, bound to the top level
`include "first_fit_block_allocator_core_macros.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `FFBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `FFBA_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after a transfer")
    `FFBA_ASSERT_NOW(a_succ_ok, aclk, aresetn, m_tvalid && m_tdata[OUT_SUCC_BIT], m_tdata[OUT_STAT_LO +: STATUS_W] == ST_OK, "success with error status")
    `FFBA_ASSERT_NOW(a_err_clean, aclk, aresetn, m_tvalid && (m_tdata[OUT_STAT_LO +: STATUS_W] != ST_OK), (m_tdata[RADDR_W-1:0] == '0) && !m_tdata[OUT_SUCC_BIT], "error result carries data")

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/tb_first_fit_block_allocator_core.sv -----
// self-checking testbench for the first-fit block allocator core
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_core;
    import ffba_pkg::*;

    localparam int  DESC      = 48;
    localparam int  SEGS      = 64;
    localparam int  SLOTS     = 64;
    localparam longint ADDR_LIM  = 64'd1 << 20;
    localparam int  RAND_REQS = 285;
    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    typedef struct packed {
        logic [RADDR_W-1:0]  addr;
        logic                ok;
        logic [STATUS_W-1:0] status;
        logic [LFREE_W-1:0]  largest;
    } answer_t;

    typedef struct {
        op_t                op;
        logic [REQ_W-1:0]   bytes;
        logic [ALIGN_W-1:0] align;
        logic [BADDR_W-1:0] baddr;
        bit                 fixed;
        answer_t            want;
    } req_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [HEAP_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    first_fit_block_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow heap state
    longint seg_start [SEGS];
    longint seg_size  [SEGS];
    int     seg_count;
    longint blk_user  [SLOTS];
    longint blk_base  [SLOTS];
    longint blk_span  [SLOTS];
    bit     blk_live  [SLOTS];

    answer_t pending_answers[$];
    int      errors = 0;
    bit      sink_on = 1'b0;
    longint  cycles = 0;

    function automatic void form_heap(longint h);
        if (h < 64) h = 64;
        if (h > ADDR_LIM) h = ADDR_LIM;
        foreach (blk_live[i]) blk_live[i] = 1'b0;
        seg_start[0] = DESC;
        seg_size[0]  = h - DESC;
        seg_count    = 1;
    endfunction

    function automatic void drop_seg(int k);
        for (int i = k; i + 1 < seg_count; i++) begin
            seg_start[i] = seg_start[i+1];
            seg_size[i]  = seg_size[i+1];
        end
        seg_count--;
    endfunction

    function automatic int find_block(longint a);
        for (int i = 0; i < SLOTS; i++)
            if (blk_live[i] && blk_user[i] == a) return i;
        return -1;
    endfunction

    function automatic answer_t heap_answer(op_t op, longint bytes, longint align, longint a);
        answer_t r;
        int slot, p;
        longint raw, pad, total, base, bend, best;
        bit mp, mn;
        r = '0;
        case (op)
            OP_ALLOC: begin
                slot = -1;
                if (align == 0) align = 1;
                for (int i = 0; i < SLOTS; i++)
                    if (!blk_live[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    r.status = ST_FULL;
                    return r;
                end
                for (int k = 0; k < seg_count; k++) begin
                    raw = seg_start[k] + DESC;
                    pad = (align - raw % align) % align;
                    total = bytes + DESC + pad;
                    if (seg_size[k] >= total && raw + pad < ADDR_LIM) begin
                        blk_live[slot] = 1'b1;
                        blk_user[slot] = raw + pad;
                        blk_base[slot] = raw;
                        blk_span[slot] = bytes + pad;
                        seg_start[k] += total;
                        seg_size[k]  -= total;
                        r.addr = RADDR_W'(raw + pad);
                        r.ok = 1'b1;
                        return r;
                    end
                end
                r.status = ST_NOFIT;
            end
            OP_FREE: begin
                slot = find_block(a);
                if (slot < 0) begin
                    r.status = ST_NOTOUT;
                    return r;
                end
                base = blk_base[slot];
                bend = base + blk_span[slot];
                p = 0;
                while (p < seg_count && seg_start[p] < base) p++;
                mp = p > 0 && seg_start[p-1] + seg_size[p-1] == base;
                mn = p < seg_count && seg_start[p] == bend;
                if (mp && mn) begin
                    seg_size[p-1] = seg_start[p] + seg_size[p] - seg_start[p-1];
                    drop_seg(p);
                end else if (mp) begin
                    seg_size[p-1] = bend - seg_start[p-1];
                end else if (mn) begin
                    seg_size[p] = seg_start[p] + seg_size[p] - base;
                    seg_start[p] = base;
                end else begin
                    if (seg_count >= SEGS) begin
                        r.status = ST_FULL;
                        return r;
                    end
                    for (int i = seg_count; i > p; i--) begin
                        seg_start[i] = seg_start[i-1];
                        seg_size[i]  = seg_size[i-1];
                    end
                    seg_start[p] = base;
                    seg_size[p]  = bend - base;
                    seg_count++;
                end
                blk_live[slot] = 1'b0;
                r.ok = 1'b1;
            end
            OP_COLLECT: begin
                p = 0;
                while (p + 1 < seg_count) begin
                    bend = seg_start[p] + seg_size[p];
                    if (bend == seg_start[p+1] || bend + DESC == seg_start[p+1]) begin
                        seg_size[p] = seg_start[p+1] + seg_size[p+1] - seg_start[p];
                        drop_seg(p + 1);
                    end else begin
                        p++;
                    end
                end
                r.ok = 1'b1;
            end
            OP_QUERY: r.ok = find_block(a) >= 0;
            OP_LARGEST: begin
                best = 0;
                for (int k = 0; k < seg_count; k++)
                    if (seg_size[k] > best) best = seg_size[k];
                r.largest = LFREE_W'(best);
                r.ok = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    endfunction

    // tvalid stays up after a transfer until a later call or write_heap drops it, or the next call reuses it
    task automatic send_req(int unsigned op, longint bytes, longint align, longint baddr,
                            bit fixed, answer_t want);
        answer_t model;
        logic [OPCODE_W-1:0] op_b;
        logic [REQ_W-1:0]    bytes_b;
        logic [ALIGN_W-1:0]  align_b;
        logic [BADDR_W-1:0]  baddr_b;
        int gap;
        op_b    = OPCODE_W'(op);
        bytes_b = REQ_W'(bytes);
        align_b = ALIGN_W'(align);
        baddr_b = BADDR_W'(baddr);
        gap = short_or_long_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        model = heap_answer(op_t'(op_b), longint'(bytes_b), longint'(align_b),
                            longint'(baddr_b));
        if (fixed && model != want)
            $display("%0t note: table row %p differs from prediction %p", $time, want, model);
        pending_answers.push_back(fixed ? want : model);
        s_tvalid <= 1'b1;
        s_tuser  <= op_b;
        s_tdata  <= {3'b0, baddr_b, align_b, bytes_b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // result side with random stalls
    always @(posedge aclk) begin
        answer_t got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (m_tvalid && m_tready) begin
            got = m_tdata[RADDR_W+1+STATUS_W+LFREE_W-1:0] >> 0;
            got.addr    = m_tdata[RADDR_W-1:0];
            got.ok      = m_tdata[OUT_SUCC_BIT];
            got.status  = m_tdata[OUT_STAT_LO +: STATUS_W];
            got.largest = m_tdata[OUT_LFREE_LO +: LFREE_W];
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected transfer: actual %p", $time, got);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (got != want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
        if (sink_on) m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
        else m_tready <= 1'b0;
    end

    task automatic write_heap(logic [HEAP_W-1:0] h);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        form_heap(longint'(h));
    endtask

    task automatic random_phase(int count, int size_top);
        longint addr_pick;
        int op, n;
        for (n = 0; n < count; n++) begin
            op = $urandom_range(0, 15);
            addr_pick = $urandom_range(0, SLOTS - 1);
            // frees and queries use a live block's address three times in four when the picked slot is live
            if (blk_live[addr_pick] && $urandom_range(0, 3) != 0) addr_pick = blk_user[addr_pick];
            else addr_pick = $urandom_range(0, 20'hFFFFF);
            if (op < 7)
                send_req(OP_ALLOC, ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, size_top),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64), $urandom,
                         1'b0, '0);
            else if (op < 11) send_req(OP_FREE, $urandom, $urandom, addr_pick, 1'b0, '0);
            else if (op == 11) send_req(OP_COLLECT, $urandom, $urandom, $urandom, 1'b0, '0);
            else if (op == 12) send_req(OP_QUERY, $urandom, $urandom, addr_pick, 1'b0, '0);
            else if (op == 13) send_req(OP_LARGEST, $urandom, $urandom, $urandom, 1'b0, '0);
            else send_req($urandom_range(5, 7), $urandom, $urandom, $urandom, 1'b0, '0);
        end
    endtask

    req_row_t plan[$];

    function automatic req_row_t row(op_t op, longint b, longint al, longint a,
                                     bit fixed, answer_t w);
        req_row_t r;
        r.op = op; r.bytes = REQ_W'(b); r.align = ALIGN_W'(al); r.baddr = BADDR_W'(a);
        r.fixed = fixed; r.want = w;
        return r;
    endfunction

    initial begin
        answer_t w;
        form_heap(longint'(HEAP_RESET));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        sink_on = 1'b1;

        // directed table; fixed rows carry hard-coded expected values
        w = '0; w.ok = 1; w.largest = 21'd1048576 - DESC;
        plan.push_back(row(OP_LARGEST, 0, 1, 0, 1, w));
        w = '0; w.status = ST_NOTOUT;
        plan.push_back(row(OP_FREE, 0, 1, 20'hFFFFF, 1, w));
        w = '0; w.addr = 96; w.ok = 1;
        plan.push_back(row(OP_ALLOC, 0, 0, 0, 1, w));
        w = '0; w.ok = 1;
        plan.push_back(row(OP_QUERY, 0, 1, 96, 1, w));
        w = '0; w.status = ST_NOFIT;
        plan.push_back(row(OP_ALLOC, 20'hFFFFF, 1, 0, 1, w));
        plan.push_back(row(OP_ALLOC, 100, 4096, 0, 0, '0));
        plan.push_back(row(OP_ALLOC, 37, 13'h1FFF, 0, 0, '0));
        plan.push_back(row(OP_ALLOC, 10, 7, 0, 0, '0));
        plan.push_back(row(OP_ALLOC, 10, 1, 0, 0, '0));
        plan.push_back(row(OP_FREE, 0, 1, 96, 0, '0));
        plan.push_back(row(OP_COLLECT, 0, 1, 0, 0, '0));
        plan.push_back(row(OP_LARGEST, 0, 1, 0, 0, '0));
        w = '0;
        plan.push_back(row(op_t'(3'd5), 20'hFFFFF, 13'h1FFF, 20'hFFFFF, 1, w));
        plan.push_back(row(op_t'(3'd7), 0, 0, 0, 1, w));
        plan.push_back(row(OP_QUERY, 0, 1, 0, 0, '0));
        foreach (plan[i])
            send_req(plan[i].op, plan[i].bytes, plan[i].align, plan[i].baddr,
                     plan[i].fixed, plan[i].want);

        // fill the used table, then free every other block to split the free table
        write_heap(21'd20000);
        for (int i = 0; i < SLOTS + 1; i++) send_req(OP_ALLOC, 8, 1, 0, 0, '0);
        for (int i = 0; i < SLOTS; i += 2) send_req(OP_FREE, 0, 1, 48 + 56 * i + 48, 0, '0);
        send_req(OP_ALLOC, 100000, 1, 0, 0, '0);
        send_req(OP_COLLECT, 0, 1, 0, 0, '0);
        send_req(OP_LARGEST, 0, 1, 0, 0, '0);

        write_heap(21'd64);
        random_phase(20, 40);
        write_heap(21'h1FFFFF);
        random_phase(30, 4096);
        write_heap(21'd0);
        random_phase(15, 40);
        write_heap(21'd3000);
        random_phase(100, 200);
        write_heap(HEAP_RESET);
        random_phase(RAND_REQS - 165, 20000);

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_mod_unit.sv
rtl/core/first_fit_block_allocator_core.sv
rtl/core/ffba_checker.sv
sim/tb_first_fit_block_allocator_core.sv
